/* src/ghtab_pkg.sv */
// ghtab_pkg: command codes, status codes and constants for the handle table
// no dependencies
package ghtab_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 2;

  localparam logic [CmdW-1:0] CmdOpen  = 2'd0;
  localparam logic [CmdW-1:0] CmdClose = 2'd1;
  localparam logic [CmdW-1:0] CmdCheck = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam logic [WordW-1:0] GenReset = 32'd1;

endpackage

/* src/generational_handle_table.sv */
// generational_handle_table: top level, two-stage command pipe and result register
// depends on ghtab_pkg, ghtab_alloc, ghtab_ram
//
//   channel | valid       | stall        | payload
//   in      | in_valid_i  | in_stall_o   | command_i, handle_index_i, handle_generation_i
//   out     | out_valid_o | out_stall_i  | status_o, issued_index_o, issued_generation_o
//
// one beat per cycle while in_stall_o is low; a result passes the input register, the
// generation ram read and the result register, and leaves once out_stall_i is low
// after reset the generation ram is swept to one, slot by slot, with in_stall_o high
// a held result freezes the whole pipe, so in_stall_o is high while out_valid_o and
// out_stall_i are both high
module generational_handle_table
  import ghtab_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [WordW-1:0]  handle_index_i,
  input  logic [WordW-1:0]  handle_generation_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [WordW-1:0]  issued_index_o,
  output logic [WordW-1:0]  issued_generation_o
);

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic             adv, accept;
  logic             clearing_q;
  logic [SlotW-1:0] clr_cnt_q;

  // stage 1
  logic             s1_valid_q;
  logic [CmdW-1:0]  s1_cmd_q;
  logic [WordW-1:0] s1_idx_q, s1_gen_q;
  logic             s1_open, s1_in_range, s1_hit;
  logic [SlotW-1:0] lookup_slot, free_slot, rd_slot;
  logic             full, lookup_active;

  // stage 2
  logic             s2_valid_q;
  logic [CmdW-1:0]  s2_cmd_q;
  logic [SlotW-1:0] s2_slot_q;
  logic             s2_hit_q;
  logic [WordW-1:0] s2_hgen_q;
  logic             fwd_en_q;
  logic [WordW-1:0] fwd_data_q;
  logic [WordW-1:0] ram_rdata, cur_gen;
  logic             close_ok;
  status_e          s2_status;
  logic [WordW-1:0] s2_idx, s2_gen;

  // generation writes
  logic             gen_we, ram_we;
  logic [WordW-1:0] gen_wdata, ram_wdata;
  logic [SlotW-1:0] ram_waddr;

  // result register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [WordW-1:0] out_idx_q, out_gen_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = clearing_q || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + SlotW'(1);
      if (clr_cnt_q == SlotW'(SLOT_COUNT - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // stage 1: slot choice and active lookup
  assign s1_open     = (s1_cmd_q == CmdOpen);
  assign s1_in_range = (s1_idx_q != '0) && (s1_idx_q <= WordW'(SLOT_COUNT));
  assign lookup_slot = SlotW'(s1_idx_q - WordW'(1));
  assign rd_slot     = s1_open ? free_slot : lookup_slot;
  assign s1_hit      = s1_open ? !full : (s1_in_range && lookup_active);

  ghtab_alloc #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_alloc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (adv),
    .clr_en_i       (close_ok),
    .clr_slot_i     (s2_slot_q),
    .set_en_i       (s1_valid_q && s1_open),
    .lookup_slot_i  (lookup_slot),
    .free_slot_o    (free_slot),
    .full_o         (full),
    .lookup_active_o(lookup_active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= command_i;
      s1_idx_q <= handle_index_i;
      s1_gen_q <= handle_generation_i;
    end
  end

  // stage 2: generation compare and update
  assign cur_gen   = fwd_en_q ? fwd_data_q : ram_rdata;
  assign close_ok  = s2_valid_q && (s2_cmd_q == CmdClose) && s2_hit_q
                     && (cur_gen == s2_hgen_q);
  assign gen_we    = close_ok && adv;
  assign gen_wdata = cur_gen + WordW'(1);

  always_comb begin
    s2_status = ST_INVALID;
    s2_idx    = '0;
    s2_gen    = '0;
    case (s2_cmd_q)
      CmdOpen: begin
        if (s2_hit_q) begin
          s2_status = ST_OK;
          s2_idx    = WordW'(s2_slot_q) + WordW'(1);
          s2_gen    = cur_gen;
        end else begin
          s2_status = ST_FULL;
        end
      end
      CmdClose, CmdCheck: begin
        if (s2_hit_q && (cur_gen == s2_hgen_q)) begin
          s2_status = ST_OK;
        end
      end
      default: s2_status = ST_INVALID;
    endcase
  end

  assign ram_we    = clearing_q || gen_we;
  assign ram_waddr = clearing_q ? clr_cnt_q : s2_slot_q;
  assign ram_wdata = clearing_q ? GenReset : gen_wdata;

  ghtab_ram #(
    .Width(WordW),
    .Depth(SLOT_COUNT)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (adv),
    .raddr_i(rd_slot),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // a write landing on the slot being read overtakes the ram data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_slot_q  <= rd_slot;
      s2_hit_q   <= s1_hit;
      s2_hgen_q  <= s1_gen_q;
      fwd_en_q   <= gen_we && (s2_slot_q == rd_slot);
      fwd_data_q <= gen_wdata;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_status_q <= s2_status;
      out_idx_q    <= s2_idx;
      out_gen_q    <= s2_gen;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign issued_index_o      = out_idx_q;
  assign issued_generation_o = out_gen_q;

endmodule

/* src/ghtab_ram.sv */
// ghtab_ram: generic single write port, single read port ram, registered read
// no dependencies
module ghtab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ghtab_alloc.sv */
// ghtab_alloc: active bit vector, lowest-free search and active lookup
// depends on nothing but its parameters
module ghtab_alloc #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic             clr_en_i,
  input  logic [SlotW-1:0] clr_slot_i,
  input  logic             set_en_i,
  input  logic [SlotW-1:0] lookup_slot_i,
  output logic [SlotW-1:0] free_slot_o,
  output logic             full_o,
  output logic             lookup_active_o
);

  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_COUNT-1:0] eff;
  logic [SLOT_COUNT-1:0] set_dec;

  // close in the later stage frees its slot for an open in the same cycle
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      eff[i] = active_q[i] & ~(clr_en_i && (clr_slot_i == SlotW'(i)));
    end
  end

  always_comb begin
    free_slot_o     = '0;
    lookup_active_o = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!eff[i]) begin
        free_slot_o = SlotW'(i);
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (lookup_slot_i == SlotW'(i)) begin
        lookup_active_o = eff[i];
      end
    end
  end

  assign full_o = &eff;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      set_dec[i] = set_en_i && !full_o && (free_slot_o == SlotW'(i));
    end
    active_d = upd_i ? (eff | set_dec) : active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      active_q <= active_d;
    end
  end

endmodule
